/* hdl/mhs_pkg.sv */
// shared types and constants for the motor homing sequencer
// no dependencies
package mhs_pkg;

    typedef enum logic [2:0] {
        PH_INIT        = 3'd0,
        PH_WAIT_SWITCH = 3'd1,
        PH_START_MOVE  = 3'd2,
        PH_WAIT_MOVE   = 3'd3,
        PH_RUN         = 3'd4,
        PH_DEACT       = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRACK,
        ST_DECIDE,
        ST_DIVIDE,
        ST_LAW,
        ST_CLAMP,
        ST_OUT
    } ctrl_state_t;

    localparam logic [2:0] CFG_SPEED_MODE   = 3'd0;
    localparam logic [2:0] CFG_MAX_DUTY     = 3'd1;
    localparam logic [2:0] CFG_TARGET_SPEED = 3'd2;
    localparam logic [2:0] CFG_FEEDFORWARD  = 3'd3;
    localparam logic [2:0] CFG_SPEED_GAIN   = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT      = 3'd5;
    localparam logic [2:0] CFG_HOME_POS     = 3'd6;
    localparam logic [2:0] CFG_POS_SCALE    = 3'd7;

    localparam logic [1:0] MOVE_RUNNING = 2'd0;
    localparam logic [1:0] MOVE_DONE    = 2'd1;

    localparam int DIV_BITS = 26;

    typedef struct packed {
        logic start;
        logic track;
        logic decide;
        logic div_step;
        logic law;
        logic clamp;
        logic publish;
    } mhs_cmd_t;

    typedef struct packed {
        logic need_speed;
        logic div_done;
    } mhs_status_t;

endpackage

/* hdl/motor_homing_sequencer_top.sv */
// Homing sequencer for a DC motor with a limit switch. One input transaction
// is one 1 ms tick and yields one output transaction. On a 25 ms
// speed-measurement tick in speed mode, a radix-2 serial divider (one quotient
// bit per cycle over 26 bits) computes the speed; one tick is in flight at a
// time and the output register lets the next tick enter while a result waits.
// The user is to write configuration only while idle; the block does not enforce this.
// depends on mhs_pkg, mhs_ctrl, mhs_datapath
module motor_homing_sequencer_top #(
    parameter int INVERT_DIRECTION = 0,
    parameter int TIME_BITS        = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               switch_level,
    input  logic               power_on,
    input  logic signed [15:0] encoder_value,
    input  logic [1:0]         move_status,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        pwm_duty,
    output logic               pwm_enable,
    output logic               direction,
    output logic               encoder_clear,
    output logic               move_request,
    output logic [2:0]         phase,
    output logic               ready_res,
    output logic signed [31:0] position
);
    import mhs_pkg::*;

    mhs_cmd_t    cmd;
    mhs_status_t status;

    mhs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mhs_datapath #(
        .INVERT_DIRECTION (INVERT_DIRECTION),
        .TIME_BITS        (TIME_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_switch_level  (switch_level),
        .in_power_on      (power_on),
        .in_encoder_value (encoder_value),
        .in_move_status   (move_status),
        .cmd              (cmd),
        .status           (status),
        .pwm_duty         (pwm_duty),
        .pwm_enable       (pwm_enable),
        .direction        (direction),
        .encoder_clear    (encoder_clear),
        .move_request     (move_request),
        .phase            (phase),
        .ready_res        (ready_res),
        .position         (position)
    );
endmodule

/* hdl/mhs_ctrl.sv */
// controller state machine sequencing one tick through the datapath
// depends on mhs_pkg
module mhs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  mhs_pkg::mhs_status_t status,
    output mhs_pkg::mhs_cmd_t    cmd
);
    import mhs_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_TRACK;
                end
            end
            ST_TRACK:
            begin
                cmd.track  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.need_speed ? ST_DIVIDE : ST_OUT;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_LAW;
                end
            end
            ST_LAW:
            begin
                cmd.law    = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_pub_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> state_reg == ST_IDLE && out_valid_reg)
        else $error("publish did not return to idle");
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("input taken while busy");
    a_start_track: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> state_reg == ST_TRACK)
        else $error("start did not enter track");
`endif
endmodule

/* hdl/mhs_datapath.sv */
// datapath: timers, phase logic, speed divider, duty law and position
// depends on mhs_pkg
module mhs_datapath #(
    parameter int INVERT_DIRECTION = 0,
    parameter int TIME_BITS        = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_switch_level,
    input  logic                 in_power_on,
    input  logic signed [15:0]   in_encoder_value,
    input  logic [1:0]           in_move_status,
    input  mhs_pkg::mhs_cmd_t    cmd,
    output mhs_pkg::mhs_status_t status,
    output logic [15:0]          pwm_duty,
    output logic                 pwm_enable,
    output logic                 direction,
    output logic                 encoder_clear,
    output logic                 move_request,
    output logic [2:0]           phase,
    output logic                 ready_res,
    output logic signed [31:0]   position
);
    import mhs_pkg::*;

    localparam int TB = TIME_BITS;

    logic        speed_mode_reg;
    logic [15:0] max_duty_reg, target_reg, timeout_reg;
    logic [7:0]  kv_reg, kp_reg;
    logic signed [7:0] scale_reg;

    logic        sw_reg, pw_reg;
    logic signed [15:0] enc_reg;
    logic [1:0]  mst_reg;

    logic [TB-1:0] now_reg, press_start_reg, power_start_reg, measure_reg;
    phase_t      phase_reg, prev_reg;
    logic        press_valid_reg, power_seen_reg, tracking_reg, done_reg, pwm_on_reg;
    logic signed [15:0] enc_ref_reg;
    logic signed [31:0] pos_reg;
    logic [15:0] duty_reg;
    logic [DIV_BITS-1:0] filt_reg;
    logic        clear_reg, request_reg;

    logic [DIV_BITS-1:0] rem_reg, quo_reg;
    logic [TB-1:0]       dt_reg;
    logic [4:0]          div_cnt_reg;
    logic signed [41:0]  law_reg;

    logic [15:0] o_duty_reg;
    logic        o_en_reg, o_clr_reg, o_req_reg, o_done_reg;
    logic [2:0]  o_phase_reg;
    logic signed [31:0] o_pos_reg;

    logic signed [16:0] delta;
    logic signed [16:0] delta_w;
    logic signed [25:0] prod;
    logic signed [33:0] acc;
    logic [TB-1:0] now1;
    logic [TB-1:0] el_meas, el_press, el_power;
    logic [15:0] pulses;
    logic [32:0] trial;
    logic [DIV_BITS-1:0] rem_sh;
    logic [DIV_BITS:0] sum_sp;
    logic [DIV_BITS-1:0] spd;
    logic [23:0] ff_prod;
    logic signed [26:0] spd_err;
    logic signed [35:0] fb_prod;

    always_comb
    begin
        delta = 17'(enc_reg) - 17'(enc_ref_reg);
        if (delta > 17'sd32000)
        begin
            delta_w = delta - 17'sd65536;
        end
        else if (delta < -17'sd32000)
        begin
            delta_w = delta + 17'sd65536;
        end
        else
        begin
            delta_w = delta;
        end
        prod   = 26'(delta_w) * 26'(scale_reg);
        acc    = 34'(pos_reg) + 34'(prod);
        now1   = now_reg;
        el_meas  = now_reg - measure_reg;
        el_press = now_reg - press_start_reg;
        el_power = now_reg - power_start_reg;
        pulses = enc_reg[15] ? 16'(-enc_reg) : 16'(enc_reg);
        rem_sh = {rem_reg[DIV_BITS-2:0], quo_reg[DIV_BITS-1]};
        trial  = 33'(rem_sh) - 33'(dt_reg);
        sum_sp = (DIV_BITS+1)'(quo_reg) + (DIV_BITS+1)'(filt_reg);
        spd    = DIV_BITS'(sum_sp >> 1);
        ff_prod = 24'(target_reg) * 24'(kv_reg);
        spd_err = 27'(target_reg) - 27'(spd);
        fb_prod = 36'(spd_err) * 36'($signed({1'b0, kp_reg}));
    end

    assign status.need_speed = speed_mode_reg && phase_reg == PH_WAIT_SWITCH
                               && prev_reg == PH_WAIT_SWITCH && el_meas >= TB'(25);
    assign status.div_done   = div_cnt_reg == 5'(DIV_BITS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_mode_reg <= 1'b0;
            max_duty_reg   <= '0;
            target_reg     <= '0;
            timeout_reg    <= '0;
            kv_reg         <= '0;
            kp_reg         <= '0;
            scale_reg      <= 8'sd1;
            now_reg        <= '0;
            press_start_reg <= '0;
            power_start_reg <= '0;
            measure_reg    <= '0;
            phase_reg      <= PH_INIT;
            prev_reg       <= PH_DEACT;
            press_valid_reg <= 1'b0;
            power_seen_reg <= 1'b0;
            tracking_reg   <= 1'b0;
            done_reg       <= 1'b0;
            pwm_on_reg     <= 1'b0;
            enc_ref_reg    <= '0;
            pos_reg        <= '0;
            duty_reg       <= '0;
            filt_reg       <= '0;
            clear_reg      <= 1'b0;
            request_reg    <= 1'b0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            dt_reg         <= '0;
            law_reg        <= '0;
            div_cnt_reg    <= '0;
            o_duty_reg     <= '0;
            o_en_reg       <= 1'b0;
            o_clr_reg      <= 1'b0;
            o_req_reg      <= 1'b0;
            o_done_reg     <= 1'b0;
            o_phase_reg    <= PH_INIT;
            o_pos_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SPEED_MODE:   speed_mode_reg <= cfg_data[0];
                    CFG_MAX_DUTY:     max_duty_reg   <= cfg_data;
                    CFG_TARGET_SPEED: target_reg     <= cfg_data;
                    CFG_FEEDFORWARD:  kv_reg         <= cfg_data[7:0];
                    CFG_SPEED_GAIN:   kp_reg         <= cfg_data[7:0];
                    CFG_TIMEOUT:      timeout_reg    <= cfg_data;
                    CFG_POS_SCALE:    scale_reg      <= cfg_data[7:0];
                    default:          ;
                endcase
            end
            if (cmd.start)
            begin
                now_reg     <= now_reg + TB'(1);
                clear_reg   <= 1'b0;
                request_reg <= 1'b0;
            end
            if (cmd.track && tracking_reg)
            begin
                enc_ref_reg <= enc_reg;
                if (acc > 34'sh7FFFFFFF)
                begin
                    pos_reg <= 32'sh7FFFFFFF;
                end
                else if (acc < -34'sh80000000)
                begin
                    pos_reg <= 32'sh80000000;
                end
                else
                begin
                    pos_reg <= 32'(acc);
                end
            end
            if (cmd.decide)
            begin
                prev_reg <= phase_reg;
                case (phase_reg)
                    PH_INIT:
                    begin
                        press_valid_reg <= 1'b0;
                        press_start_reg <= '0;
                        power_start_reg <= '0;
                        power_seen_reg  <= 1'b0;
                        tracking_reg    <= 1'b0;
                        enc_ref_reg     <= '0;
                        pos_reg         <= '0;
                        done_reg        <= 1'b0;
                        duty_reg        <= '0;
                        pwm_on_reg      <= 1'b0;
                        phase_reg       <= PH_WAIT_SWITCH;
                    end
                    PH_WAIT_SWITCH:
                    begin
                        if (prev_reg != PH_WAIT_SWITCH)
                        begin
                            if (!speed_mode_reg)
                            begin
                                duty_reg   <= max_duty_reg;
                                pwm_on_reg <= 1'b1;
                            end
                            measure_reg <= now1;
                            filt_reg    <= '0;
                        end
                        if (!power_seen_reg && pw_reg)
                        begin
                            power_start_reg <= now1;
                        end
                        power_seen_reg <= pw_reg;
                        if (status.need_speed)
                        begin
                            clear_reg   <= 1'b1;
                            measure_reg <= now1;
                            dt_reg      <= el_meas;
                            rem_reg     <= '0;
                            quo_reg     <= DIV_BITS'(pulses) * DIV_BITS'(1000);
                            div_cnt_reg <= '0;
                        end
                        if (!sw_reg && press_valid_reg && el_press > TB'(50))
                        begin
                            duty_reg     <= '0;
                            pwm_on_reg   <= 1'b1;
                            clear_reg    <= 1'b1;
                            tracking_reg <= 1'b1;
                            enc_ref_reg  <= '0;
                            phase_reg    <= PH_START_MOVE;
                        end
                        else if (pw_reg && (TB+1)'(
                                 (!power_seen_reg) ? TB'(0) : el_power)
                                 > (TB+1)'(timeout_reg) + (TB+1)'(1000))
                        begin
                            phase_reg <= PH_DEACT;
                        end
                        if (sw_reg)
                        begin
                            press_valid_reg <= 1'b0;
                        end
                        else if (!press_valid_reg || prev_reg != PH_WAIT_SWITCH)
                        begin
                            press_start_reg <= now1;
                            press_valid_reg <= 1'b1;
                        end
                    end
                    PH_START_MOVE:
                    begin
                        request_reg <= 1'b1;
                        phase_reg   <= PH_WAIT_MOVE;
                    end
                    PH_WAIT_MOVE:
                    begin
                        if (mst_reg == MOVE_DONE)
                        begin
                            done_reg  <= 1'b1;
                            phase_reg <= PH_RUN;
                        end
                        else if (mst_reg != MOVE_RUNNING)
                        begin
                            phase_reg <= PH_DEACT;
                        end
                    end
                    PH_RUN:
                    begin
                    end
                    default:
                    begin
                        if (prev_reg != phase_reg)
                        begin
                            pwm_on_reg <= 1'b0;
                        end
                    end
                endcase
            end
            if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
                quo_reg     <= {quo_reg[DIV_BITS-2:0], !trial[32]};
                rem_reg     <= trial[32] ? rem_sh : trial[DIV_BITS-1:0];
            end
            if (cmd.law)
            begin
                filt_reg <= spd;
                law_reg  <= 42'(fb_prod) + 42'(ff_prod);
            end
            if (cmd.clamp)
            begin
                pwm_on_reg <= 1'b1;
                // switch found on this tick keeps the duty at zero
                if (phase_reg != PH_START_MOVE)
                begin
                    if (law_reg < 0)
                    begin
                        duty_reg <= '0;
                    end
                    else if (law_reg > 42'(max_duty_reg))
                    begin
                        duty_reg <= max_duty_reg;
                    end
                    else
                    begin
                        duty_reg <= law_reg[15:0];
                    end
                end
            end
            if (cmd.publish)
            begin
                o_duty_reg  <= duty_reg;
                o_en_reg    <= pwm_on_reg;
                o_clr_reg   <= clear_reg;
                o_req_reg   <= request_reg;
                o_phase_reg <= phase_reg;
                o_done_reg  <= done_reg;
                o_pos_reg   <= pos_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sw_reg  <= in_switch_level;
            pw_reg  <= in_power_on;
            enc_reg <= in_encoder_value;
            mst_reg <= in_move_status;
        end
    end

    assign pwm_duty      = o_duty_reg;
    assign pwm_enable    = o_en_reg;
    assign direction     = INVERT_DIRECTION[0];
    assign encoder_clear = o_clr_reg;
    assign move_request  = o_req_reg;
    assign phase         = o_phase_reg;
    assign ready_res     = o_done_reg;
    assign position      = o_pos_reg;

`ifndef ASSERT_OFF
    a_req_phase: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish && request_reg |=> o_phase_reg == PH_WAIT_MOVE)
        else $error("move request outside start move");
    a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish && done_reg |=> o_phase_reg == PH_RUN)
        else $error("ready outside run");
    a_deact_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide && phase_reg == PH_DEACT |=> phase_reg == PH_DEACT)
        else $error("left deactivated phase");
`endif
endmodule
